FILE: rtl/core/uvs_pkg.sv
`default_nettype none

package uvs_pkg;

    // register indexes (byte address = 4 * index)
    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_RADIUS  = 2'd0;
    localparam t_reg_idx REG_SECTORS = 2'd1;
    localparam t_reg_idx REG_STACKS  = 2'd2;

    // reset values
    localparam logic [15:0] RADIUS_RST  = 16'd256;
    localparam logic [10:0] SECTORS_RST = 11'd36;
    localparam logic [10:0] STACKS_RST  = 11'd18;

    // CORDIC constants, Q2.30 and phase units (2^32 = one turn)
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
    localparam int ATAN_ENTRIES = 24;

    typedef logic signed [31:0] t_phase;
    localparam t_phase ATAN_TURN [ATAN_ENTRIES] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    // output tdata layout
    localparam int OUT_DATA_W = 136;

endpackage

`default_nettype wire

FILE: rtl/core/uv_sphere_vertex_gen.sv
// Channel  | Dir | Signals                          | Content
// s        | in  | i_s_tvalid/o_s_tready/i_s_tdata  | stack_index, sector_index
// m        | out | o_m_tvalid/i_m_tready/o_m_tdata | position, normal, texture coords
//          |     | o_m_tuser                        | index_bad
// apb      | in  | psel/penable/pwrite/paddr/...    | radius, sector and stack counts
//
// One grid point per cycle while m does not stall; each point passes through the
// 32-step restoring division chain and the CORDIC rotation pipeline.
// Synchronous active-low reset clears valid bits and loads register defaults.
// A stall on m freezes every stage; o_s_tready follows the output slot.
`default_nettype none

module uv_sphere_vertex_gen #(
    parameter int MAX_SEGMENTS  = 1024,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // [10:0] stack_index, [21:11] sector_index, [23:22] zero
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [23:0]  i_s_tdata,
    // [16:0] pos_x, [33:17] pos_y, [50:34] pos_z, [66:51] norm_x,
    // [82:67] norm_y, [98:83] norm_z, [115:99] tex_s, [132:116] tex_t, rest zero
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [135:0]      o_m_tdata,
    // [0] index_bad
    output logic [0:0]        o_m_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]      prdata,
    output logic              pready
);

    localparam int NDIV = 32;
    localparam int PF   = NDIV + 1;
    localparam int U    = PF + CORDIC_STAGES + 1;
    localparam int M1   = U + 1;
    localparam int M2   = U + 2;
    localparam int M3   = U + 3;
    localparam int OUTS = U + 4;
    localparam int LAT  = OUTS + 1;

    // configuration registers
    logic [15:0] r_radius;
    logic [10:0] r_sectors;
    logic [10:0] r_stacks;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius  <= uvs_pkg::RADIUS_RST;
            r_sectors <= uvs_pkg::SECTORS_RST;
            r_stacks  <= uvs_pkg::STACKS_RST;
        end else if (psel && penable && pwrite) begin
            case (uvs_pkg::t_reg_idx'(paddr[3:2]))
                uvs_pkg::REG_RADIUS:  r_radius  <= pwdata[15:0];
                uvs_pkg::REG_SECTORS: r_sectors <= pwdata[10:0];
                uvs_pkg::REG_STACKS:  r_stacks  <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (uvs_pkg::t_reg_idx'(paddr[3:2]))
            uvs_pkg::REG_RADIUS:  prdata = {16'd0, r_radius};
            uvs_pkg::REG_SECTORS: prdata = {21'd0, r_sectors};
            uvs_pkg::REG_STACKS:  prdata = {21'd0, r_stacks};
            default:              prdata = 32'd0;
        endcase
    end

    // clamped counts
    logic [10:0] secs;
    logic [10:0] stks;
    always_comb begin
        if (r_sectors < 11'd3)                         secs = 11'd3;
        else if ({2'b0, r_sectors} > 13'(MAX_SEGMENTS)) secs = 11'(MAX_SEGMENTS);
        else                                           secs = r_sectors;
        if (r_stacks < 11'd2)                          stks = 11'd2;
        else if ({2'b0, r_stacks} > 13'(MAX_SEGMENTS))  stks = 11'(MAX_SEGMENTS);
        else                                           stks = r_stacks;
    end

    // global advance: every stage moves when the output slot frees up
    logic en;
    assign en = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    logic r_vld [LAT];
    logic r_bad [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_s_tvalid;
            for (int k = 1; k < LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    logic [10:0] in_i;
    logic [10:0] in_j;
    assign in_i = i_s_tdata[10:0];
    assign in_j = i_s_tdata[21:11];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bad[0] <= (in_i > stks) || (in_j > secs);
            for (int k = 1; k < LAT; k++) r_bad[k] <= r_bad[k-1];
        end
    end

    // division lanes: 0 phase v (32 frac bits), 1 phase offset u (31),
    // 2 tex_s (16), 3 tex_t (16); even lanes divide by sectors, odd by stacks
    logic [31:0] r_dq  [NDIV+1][4];
    logic [10:0] r_drm [NDIV+1][4];
    logic        r_dhi [NDIV+1][4];

    // lane start: integer part of index/count is 0 or 1
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 4; l++) begin
                r_dq[0][l] <= 32'd0;
                if (l % 2 == 0) begin
                    r_dhi[0][l] <= (in_j == secs);
                    r_drm[0][l] <= (in_j == secs) ? 11'd0 : in_j;
                end else begin
                    r_dhi[0][l] <= (in_i == stks);
                    r_drm[0][l] <= (in_i == stks) ? 11'd0 : in_i;
                end
            end
        end
    end

    // one quotient bit per stage and lane, in the stages that lie within the lane's fraction bits
    for (genvar k = 0; k < NDIV; k++) begin : g_div
        for (genvar l = 0; l < 4; l++) begin : g_lane
            localparam int B = NDIV - 1 - k;
            localparam int F = (l == 0) ? 32 : (l == 1) ? 31 : 16;
            logic [10:0] dv;
            logic        nb;
            logic [11:0] tr;
            logic        ge;
            assign dv = (l % 2 == 0) ? secs : stks;
            // rounding term is count/2, fed in at the low bits
            if (B < 10) begin : g_h
                assign nb = dv[B+1];
            end else begin : g_z
                assign nb = 1'b0;
            end
            assign tr = {r_drm[k][l], nb};
            assign ge = tr >= {1'b0, dv};

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dhi[k+1][l] <= r_dhi[k][l];
                    if (B < F) begin
                        r_drm[k+1][l] <= ge ? 11'(tr - {1'b0, dv}) : tr[10:0];
                        r_dq[k+1][l]  <= {r_dq[k][l][30:0], ge};
                    end else begin
                        r_drm[k+1][l] <= r_drm[k][l];
                        r_dq[k+1][l]  <= r_dq[k][l];
                    end
                end
            end
        end
    end

    // phases from the division results
    logic [31:0] ph_v;
    logic [31:0] ph_u;
    assign ph_v = r_dq[NDIV][0];
    assign ph_u = 32'h4000_0000 - {r_dhi[NDIV][1], r_dq[NDIV][1][30:0]};

    logic [16:0] r_texs [PF:OUTS-1];
    logic [16:0] r_text [PF:OUTS-1];

    // angle 0 is u (stack), angle 1 is v (sector)
    logic [1:0]        r_quad [PF:U-1][2];
    logic              r_zero [PF:U-1][2];
    logic signed [31:0] r_z   [PF:U-1][2];
    logic signed [33:0] r_x   [PF:U-1][2];
    logic signed [33:0] r_y   [PF:U-1][2];

    // quadrant fold
    for (genvar a = 0; a < 2; a++) begin : g_fold
        logic [31:0] ph;
        logic [1:0]  qd;
        logic [31:0] ru;
        assign ph = (a == 0) ? ph_u : ph_v;
        assign qd = 2'((ph + 32'h2000_0000) >> 30);
        assign ru = ph - {qd, 30'd0};
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_quad[PF][a] <= qd;
                r_zero[PF][a] <= (ru == 32'd0);
                r_z[PF][a]    <= $signed(ru);
                r_x[PF][a]    <= (ru == 32'd0) ? uvs_pkg::Q30_ONE : uvs_pkg::CORDIC_GAIN;
                r_y[PF][a]    <= 34'sd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_texs[PF] <= {r_dhi[NDIV][2], r_dq[NDIV][2][15:0]};
            r_text[PF] <= {r_dhi[NDIV][3], r_dq[NDIV][3][15:0]};
            for (int k = PF + 1; k < OUTS; k++) begin
                r_texs[k] <= r_texs[k-1];
                r_text[k] <= r_text[k-1];
            end
        end
    end

    // CORDIC rotation stages
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cord
        for (genvar a = 0; a < 2; a++) begin : g_ang
            localparam int S = PF + k;
            logic signed [33:0] xs;
            logic signed [33:0] ys;
            assign xs = r_x[S][a] >>> k;
            assign ys = r_y[S][a] >>> k;
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_quad[S+1][a] <= r_quad[S][a];
                    r_zero[S+1][a] <= r_zero[S][a];
                    if (r_zero[S][a]) begin
                        r_x[S+1][a] <= r_x[S][a];
                        r_y[S+1][a] <= r_y[S][a];
                        r_z[S+1][a] <= r_z[S][a];
                    end else if (r_z[S][a] >= 0) begin
                        r_x[S+1][a] <= r_x[S][a] - ys;
                        r_y[S+1][a] <= r_y[S][a] + xs;
                        r_z[S+1][a] <= r_z[S][a] - uvs_pkg::ATAN_TURN[k];
                    end else begin
                        r_x[S+1][a] <= r_x[S][a] + ys;
                        r_y[S+1][a] <= r_y[S][a] - xs;
                        r_z[S+1][a] <= r_z[S][a] + uvs_pkg::ATAN_TURN[k];
                    end
                end
            end
        end
    end

    // quadrant unfold
    logic signed [33:0] r_c [2];
    logic signed [33:0] r_s [2];
    localparam int CE = PF + CORDIC_STAGES;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < 2; a++) begin
                case (r_quad[CE][a])
                    2'd0: begin
                        r_c[a] <= r_x[CE][a];
                        r_s[a] <= r_y[CE][a];
                    end
                    2'd1: begin
                        r_c[a] <= -r_y[CE][a];
                        r_s[a] <= r_x[CE][a];
                    end
                    2'd2: begin
                        r_c[a] <= -r_x[CE][a];
                        r_s[a] <= -r_y[CE][a];
                    end
                    default: begin
                        r_c[a] <= r_y[CE][a];
                        r_s[a] <= -r_x[CE][a];
                    end
                endcase
            end
        end
    end

    // trig products
    logic signed [67:0] r_pcc;
    logic signed [67:0] r_pcs;
    logic signed [33:0] r_su1;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pcc <= r_c[0] * r_c[1];
            r_pcs <= r_c[0] * r_s[1];
            r_su1 <= r_s[0];
        end
    end

    // Q2.30 normal, floor of the products
    logic signed [33:0] r_n [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n[0] <= r_pcc[63:30];
            r_n[1] <= r_pcs[63:30];
            r_n[2] <= r_su1;
        end
    end

    // radius products and normal rounding
    logic signed [50:0] r_pr [3];
    logic signed [15:0] r_nq [3];
    for (genvar a = 0; a < 3; a++) begin : g_nrm
        logic signed [34:0] nr;
        logic signed [34:0] ns;
        assign nr = {r_n[a][33], r_n[a]} + 35'sd16384;
        assign ns = nr >>> 15;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_pr[a] <= $signed({1'b0, r_radius}) * r_n[a];
                if (ns > 35'sd32767)       r_nq[a] <= 16'sd32767;
                else if (ns < -35'sd32767) r_nq[a] <= -16'sd32767;
                else                       r_nq[a] <= ns[15:0];
            end
        end
    end

    logic signed [16:0] r_pos [3];
    logic signed [15:0] r_nrm [3];
    logic [16:0]        r_os;
    logic [16:0]        r_ot;

    // position rounding and saturation, then the output slot
    for (genvar a = 0; a < 3; a++) begin : g_pos
        logic signed [51:0] pr;
        logic signed [51:0] ps;
        assign pr = {r_pr[a][50], r_pr[a]} + 52'sd536870912;
        assign ps = pr >>> 30;
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_bad[OUTS-1]) begin
                    r_pos[a] <= 17'sd0;
                    r_nrm[a] <= 16'sd0;
                end else begin
                    r_nrm[a] <= r_nq[a];
                    if (ps > 52'sd65535)       r_pos[a] <= 17'sd65535;
                    else if (ps < -52'sd65535) r_pos[a] <= -17'sd65535;
                    else                       r_pos[a] <= ps[16:0];
                end
            end
        end
    end

    // texture coordinates into the output slot
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_os <= r_bad[OUTS-1] ? 17'd0 : r_texs[OUTS-1];
            r_ot <= r_bad[OUTS-1] ? 17'd0 : r_text[OUTS-1];
        end
    end

    assign o_m_tvalid = r_vld[OUTS];
    assign o_m_tuser  = r_bad[OUTS];
    assign o_m_tdata  = {3'd0, r_ot, r_os, r_nrm[2], r_nrm[1], r_nrm[0],
                         r_pos[2], r_pos[1], r_pos[0]};

    // unused product bits and final CORDIC angles kept visible only through this check term
    logic unused_ok;
    assign unused_ok = ^{r_pcc[67:64], r_pcc[29:0], r_pcs[67:64], r_pcs[29:0],
                         r_bad[LAT-1], r_z[U-1][0], r_z[U-1][1]};

endmodule

`default_nettype wire

FILE: rtl/core/uvs_chk.sv
`default_nettype none

module uvs_chk (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         o_s_tready,
    input wire logic         o_m_tvalid,
    input wire logic         i_m_tready,
    input wire logic [135:0] o_m_tdata,
    input wire logic [0:0]   o_m_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output changed under stall");

    // a bad index gives an all-zero vertex
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == 136'd0)
        else $error("bad index with nonzero data");

    // texture coordinates never pass 1.0
    a_tex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[115:99] <= 17'd65536 && o_m_tdata[132:116] <= 17'd65536)
        else $error("texture coordinate above one");

    // input side opens whenever the output slot is free or draining
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid || i_m_tready |-> o_s_tready)
        else $error("input stalled with free output slot");

endmodule

bind uv_sphere_vertex_gen uvs_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
